// ----- hdl/hssi_pkg.sv -----
// Shared types and constants for the HalfSipHash slot index block.
`default_nettype none
package hssi_pkg;

  localparam logic [31:0] INIT_C0 = 32'h6c796765;
  localparam logic [31:0] INIT_C1 = 32'h74656462;
  localparam logic [31:0] FIN1_C  = 32'h000000ee;
  localparam logic [31:0] FIN2_C  = 32'h000000dd;
  localparam logic [31:0] WORD_MASK = 32'hFFFFFFFF;

  localparam int unsigned ADDR_W = 4;

  typedef logic [3:0][31:0] sip_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSG,
    ST_FIN1,
    ST_FIN2,
    ST_MOD,
    ST_LOAD
  } hssi_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

endpackage
`default_nettype wire

// ----- hdl/hssi_round.sv -----
// One SipRound over the four 32-bit state words.
`default_nettype none
module hssi_round (
  input  hssi_pkg::sip_state_t v_in,
  output hssi_pkg::sip_state_t v_out
);

  logic [31:0] a1, b1, b2, a2, c1, d1, d2, a3, d3, c2, b3, b4, c3;

  always_comb begin
    a1 = v_in[0] + v_in[1];
    b1 = {v_in[1][26:0], v_in[1][31:27]};
    b2 = b1 ^ a1;
    a2 = {a1[15:0], a1[31:16]};
    c1 = v_in[2] + v_in[3];
    d1 = {v_in[3][23:0], v_in[3][31:24]} ^ c1;
    a3 = a2 + d1;
    d2 = {d1[24:0], d1[31:25]};
    d3 = d2 ^ a3;
    c2 = c1 + b2;
    b3 = {b2[18:0], b2[31:19]};
    b4 = b3 ^ c2;
    c3 = {c2[15:0], c2[31:16]};
    v_out[0] = a3;
    v_out[1] = b4;
    v_out[2] = c3;
    v_out[3] = d3;
  end

endmodule
`default_nettype wire

// ----- hdl/hssi_mod.sv -----
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module hssi_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  hssi_pkg::mod_req_t req,
  output logic              done,
  output logic [31:0]       remainder
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] div_r, div_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial = {rem_r, dvd_r[31]};
    diff  = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[31:0] : trial[31:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ----- hdl/halfsiphash_slot_index_core.sv -----
// Top level of the keyed HalfSipHash-2-4 slot index block.
// A non-final key word is taken in the idle state and then passes through two
// SipRounds on the shared round unit. A final word that carries 4 bytes gets
// a length tail block with two more SipRounds; each final word then runs 8
// finalization rounds, the bit-serial remainder unit and the load of the output
// register. The block takes no new request until that result sits in the
// output register, so a result that still waits there holds off the input.
`default_nettype none
module halfsiphash_slot_index_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_key_word,
  input  logic [2:0]                    in_valid_bytes,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [63:0]                   out_hash_value,
  output logic [31:0]                   out_slot_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hssi_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  hssi_pkg::hssi_state_t state_r, state_nxt;
  hssi_pkg::sip_state_t  v_r, v_nxt, v_round, v_seed, v_base;
  hssi_pkg::mod_req_t    mod_req;

  logic [63:0] seed_r;
  logic [31:0] cap_r;
  logic        key_open_r, key_open_nxt;
  logic [7:0]  len_r, len_nxt, len_sum;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] msg_r, msg_nxt, tail_r, tail_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic        tail_pend_r, tail_pend_nxt, final_r, final_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [31:0] slot_r, slot_nxt;
  logic [2:0]  nbytes;
  logic [31:0] tail_mask;
  logic        accept, round_end, out_free, mod_done;
  logic [31:0] mod_rem;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? {32'd0, cap_r} : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      cap_r  <= 32'd16;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        cap_r <= pwdata[31:0];
      end else begin
        seed_r <= pwdata;
      end
    end
  end

  hssi_round u_round (
    .v_in  (v_r),
    .v_out (v_round)
  );

  hssi_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mod_req),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign in_ready  = (state_r == hssi_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign round_end = ((state_r == hssi_pkg::ST_MSG) && (cnt_r == 2'd1)) ||
                     (((state_r == hssi_pkg::ST_FIN1) || (state_r == hssi_pkg::ST_FIN2))
                      && (cnt_r == 2'd3));

  always_comb begin
    nbytes = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
    unique case (nbytes)
      3'd0:    tail_mask = 32'h00000000;
      3'd1:    tail_mask = 32'h000000FF;
      3'd2:    tail_mask = 32'h0000FFFF;
      3'd3:    tail_mask = 32'h00FFFFFF;
      default: tail_mask = hssi_pkg::WORD_MASK;
    endcase
    v_seed[0] = seed_r[31:0];
    v_seed[1] = seed_r[63:32] ^ hssi_pkg::FIN1_C;
    v_seed[2] = hssi_pkg::INIT_C0 ^ seed_r[31:0];
    v_seed[3] = hssi_pkg::INIT_C1 ^ seed_r[63:32];
    v_base    = key_open_r ? v_r : v_seed;
    len_sum   = (key_open_r ? len_r : 8'd0) +
                ((in_last && (nbytes != 3'd4)) ? {5'd0, nbytes} : 8'd4);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hssi_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = hssi_pkg::ST_MSG;
        end
      end
      hssi_pkg::ST_MSG: begin
        if (round_end && !tail_pend_r) begin
          state_nxt = final_r ? hssi_pkg::ST_FIN1 : hssi_pkg::ST_IDLE;
        end
      end
      hssi_pkg::ST_FIN1: begin
        if (round_end) begin
          state_nxt = hssi_pkg::ST_FIN2;
        end
      end
      hssi_pkg::ST_FIN2: begin
        if (round_end) begin
          state_nxt = hssi_pkg::ST_MOD;
        end
      end
      hssi_pkg::ST_MOD: begin
        if (mod_done) begin
          state_nxt = hssi_pkg::ST_LOAD;
        end
      end
      hssi_pkg::ST_LOAD: begin
        if (out_free) begin
          state_nxt = hssi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hssi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    v_nxt         = v_r;
    key_open_nxt  = key_open_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    msg_nxt       = msg_r;
    tail_nxt      = tail_r;
    tail_pend_nxt = tail_pend_r;
    final_nxt     = final_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    hash_nxt      = hash_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mod_req.start    = 1'b0;
    mod_req.dividend = lo_r ^ v_round[1] ^ v_round[3];
    mod_req.divisor  = cap_r;
    unique case (state_r)
      hssi_pkg::ST_IDLE: begin
        if (accept) begin
          key_open_nxt = !in_last;
          len_nxt      = in_last ? 8'd0 : len_sum;
          final_nxt    = in_last;
          cnt_nxt      = 2'd0;
          tail_nxt     = {len_sum, 24'd0};
          if (in_last && (nbytes != 3'd4)) begin
            msg_nxt       = (in_key_word & tail_mask) | {len_sum, 24'd0};
            tail_pend_nxt = 1'b0;
          end else begin
            msg_nxt       = in_key_word;
            tail_pend_nxt = in_last;
          end
          v_nxt    = v_base;
          v_nxt[3] = v_base[3] ^ msg_nxt;
        end
      end
      hssi_pkg::ST_MSG: begin
        v_nxt   = v_round;
        cnt_nxt = cnt_r + 2'd1;
        if (round_end) begin
          cnt_nxt  = 2'd0;
          v_nxt[0] = v_round[0] ^ msg_r;
          if (tail_pend_r) begin
            msg_nxt       = tail_r;
            v_nxt[3]      = v_round[3] ^ tail_r;
            tail_pend_nxt = 1'b0;
          end else if (final_r) begin
            v_nxt[2] = v_round[2] ^ hssi_pkg::FIN1_C;
          end
        end
      end
      hssi_pkg::ST_FIN1: begin
        v_nxt   = v_round;
        cnt_nxt = cnt_r + 2'd1;
        if (round_end) begin
          lo_nxt   = v_round[1] ^ v_round[3];
          v_nxt[1] = v_round[1] ^ hssi_pkg::FIN2_C;
        end
      end
      hssi_pkg::ST_FIN2: begin
        v_nxt   = v_round;
        cnt_nxt = cnt_r + 2'd1;
        if (round_end) begin
          hi_nxt        = v_round[1] ^ v_round[3];
          mod_req.start = 1'b1;
        end
      end
      hssi_pkg::ST_MOD: begin
      end
      hssi_pkg::ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          hash_nxt      = {hi_r, lo_r};
          slot_nxt      = (cap_r != 32'd0) ? mod_rem : 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hssi_pkg::ST_IDLE;
      key_open_r  <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      tail_pend_r <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_open_r  <= key_open_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      tail_pend_r <= tail_pend_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    msg_r  <= msg_nxt;
    tail_r <= tail_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    hash_r <= hash_nxt;
    slot_r <= slot_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;
  assign out_slot_index = slot_r;

endmodule
`default_nettype wire
